FILE: sv/eir_pkg.sv
// Shared types and constants for the ellipse-in-rectangle rasterizer.
// No dependencies; imported by ellipse_in_rect_rasterizer_top.
`timescale 1ns / 1ps
`default_nettype none

package eir_pkg;

    // Results per rectangle are capped here
    localparam int RESULT_CAP = 64;
    localparam int CNT_W      = 7;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SCREEN_W   = 12;

    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
    localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 12'd480;

    // Register index, taken from paddr[2]
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SQA   = 8'b0000_0010,
        S_SQB   = 8'b0000_0100,
        S_DX    = 8'b0000_1000,
        S_SETUP = 8'b0001_0000,
        S_MAIN  = 8'b0010_0000,
        S_TAIL  = 8'b0100_0000,
        S_OVER  = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

FILE: sv/ellipse_in_rect_rasterizer_top.sv
// Sequencing: a rectangle is accepted in IDLE; setup then runs SQA (a*a), SQB (b*b),
// DX ((1-a)*b*b), all on one shared multiplier, then SETUP (term setup). Results are then
// loaded from MAIN and TAIL, one result per cycle while out_stall is low.
// A rectangle gives N results (N <= 64); an oversized rectangle goes from SQA to OVER
// and gives a single result. in_stall stays high until the last result is loaded.
// Reset: rst_n asynchronous, active low; sequencer idles, screen size 640 x 480.
// Depends on eir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ellipse_in_rect_rasterizer_top #(
    parameter int MAX_SPAN   = 60,
    parameter int COORD_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COORD_BITS-1:0]      corner_ax,
    input  logic signed [COORD_BITS-1:0]      corner_ay,
    input  logic signed [COORD_BITS-1:0]      corner_bx,
    input  logic signed [COORD_BITS-1:0]      corner_by,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [COORD_BITS:0]        p0_x,
    output logic signed [COORD_BITS:0]        p0_y,
    output logic signed [COORD_BITS:0]        p1_x,
    output logic signed [COORD_BITS:0]        p1_y,
    output logic signed [COORD_BITS:0]        p2_x,
    output logic signed [COORD_BITS:0]        p2_y,
    output logic signed [COORD_BITS:0]        p3_x,
    output logic signed [COORD_BITS:0]        p3_y,
    output logic [3:0]                        inside_mask,
    output logic                              last_of_shape,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [eir_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [eir_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [eir_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import eir_pkg::*;

    localparam int PW     = COORD_BITS + 1;
    localparam int SPAN_W = $clog2(MAX_SPAN + 1);
    localparam int SQ_W   = 2 * SPAN_W;
    localparam int MX_W   = SPAN_W + 1;
    localparam int MY_W   = SQ_W + 1;
    localparam int PROD_W = MX_W + MY_W;
    localparam int TERM_W = 3 * SPAN_W + 12;
    localparam int ZW     = (COORD_BITS > SCREEN_W) ? COORD_BITS : SCREEN_W;

    // ---------------- configuration ----------------
    logic [SCREEN_W-1:0] screen_width_reg;
    logic [SCREEN_W-1:0] screen_height_reg;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[SCREEN_W-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[SCREEN_W-1:0];
                default:           screen_width_reg  <= screen_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SCREEN_WIDTH:  prdata = {{(CFG_DATA_W-SCREEN_W){1'b0}}, screen_width_reg};
            REG_SCREEN_HEIGHT: prdata = {{(CFG_DATA_W-SCREEN_W){1'b0}}, screen_height_reg};
            default:           prdata = '0;
        endcase
    end

    // ---------------- registers ----------------
    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           n_reg;
    logic                       over_reg;
    logic [SPAN_W-1:0]          a_reg, b_reg;
    logic signed [COORD_BITS-1:0] minx_reg, miny_reg;
    logic [SQ_W-1:0]            aa_reg, bb_reg;
    logic signed [PROD_W-1:0]   dxm_reg;
    logic signed [PW-1:0]       lx_reg, rx_reg, ly_reg, uy_reg;
    logic signed [TERM_W-1:0]   err_reg, dx_reg, dy_reg, xinc_reg, yinc_reg;

    logic                       out_valid_reg, out_valid_next;
    logic signed [PW-1:0]       px_reg [4];
    logic signed [PW-1:0]       py_reg [4];
    logic [3:0]                 mask_reg;
    logic                       last_reg;

    logic                       slot_free;
    logic                       load;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);

    // ---------------- input decode ----------------
    logic signed [PW-1:0]         ax_e, ay_e, bx_e, by_e, dxa, dyb;
    logic [COORD_BITS-1:0]        a_full, b_full;
    logic                         oversize;
    logic signed [COORD_BITS-1:0] minx, miny;

    always_comb
    begin
        ax_e     = corner_ax;
        ay_e     = corner_ay;
        bx_e     = corner_bx;
        by_e     = corner_by;
        dxa      = bx_e - ax_e;
        dyb      = by_e - ay_e;
        a_full   = dxa[PW-1] ? COORD_BITS'(-dxa) : dxa[COORD_BITS-1:0];
        b_full   = dyb[PW-1] ? COORD_BITS'(-dyb) : dyb[COORD_BITS-1:0];
        oversize = (a_full > COORD_BITS'(MAX_SPAN)) || (b_full > COORD_BITS'(MAX_SPAN));
        minx     = (corner_ax < corner_bx) ? corner_ax : corner_bx;
        miny     = (corner_ay < corner_by) ? corner_ay : corner_by;
    end

    // ---------------- shared multiplier ----------------
    logic signed [MX_W-1:0]   mul_x;
    logic signed [MY_W-1:0]   mul_y;
    logic signed [PROD_W-1:0] prod;

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        unique case (state_reg)
            S_SQA:
            begin
                mul_x = {1'b0, a_reg};
                mul_y = {{(MY_W-SPAN_W){1'b0}}, a_reg};
            end
            S_SQB:
            begin
                mul_x = {1'b0, b_reg};
                mul_y = {{(MY_W-SPAN_W){1'b0}}, b_reg};
            end
            S_DX:
            begin
                mul_x = MX_W'(1) - {1'b0, a_reg};
                mul_y = {1'b0, bb_reg};
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        prod = mul_x * mul_y;
    end

    // ---------------- term setup ----------------
    logic                     c_bit;
    logic signed [TERM_W-1:0] aa_t, bb_t, dx_init, dy_init, err_init;
    logic signed [PW-1:0]     a_p, hb_p, ly_init;
    logic [SPAN_W:0]          b_plus;

    always_comb
    begin
        c_bit    = b_reg[0];
        aa_t     = TERM_W'(aa_reg);
        bb_t     = TERM_W'(bb_reg);
        dx_init  = TERM_W'(dxm_reg) <<< 2;
        dy_init  = c_bit ? (aa_t <<< 3) : (aa_t <<< 2);
        err_init = dx_init + dy_init + (c_bit ? aa_t : TERM_W'(0));
        a_p      = PW'(a_reg);
        b_plus   = {1'b0, b_reg} + (SPAN_W+1)'(1);
        hb_p     = PW'(b_plus[SPAN_W:1]);
        ly_init  = PW'(miny_reg) + hb_p;
    end

    // ---------------- loop step ----------------
    logic signed [TERM_W:0]   e2, dx_w, dy_w;
    logic                     xstep, ystep;
    logic signed [TERM_W-1:0] dx_n, dy_n, err_a, err_n;
    logic signed [PW-1:0]     lx_n, rx_n, ly_n, uy_n, ly_t, uy_t;
    logic signed [PW:0]       gap_m, gap_t, b_s;
    logic [CNT_W-1:0]         n_inc;
    logic                     under_cap, cont_main, cont_tail_m, cont_t;

    always_comb
    begin
        e2    = {err_reg, 1'b0};
        dx_w  = dx_reg;
        dy_w  = dy_reg;
        xstep = (e2 >= dx_w);
        ystep = (e2 <= dy_w);
        dx_n  = xstep ? dx_reg + xinc_reg : dx_reg;
        err_a = xstep ? err_reg + dx_n : err_reg;
        dy_n  = ystep ? dy_reg + yinc_reg : dy_reg;
        err_n = ystep ? err_a + dy_n : err_a;
        lx_n  = xstep ? lx_reg + PW'(1) : lx_reg;
        rx_n  = xstep ? rx_reg - PW'(1) : rx_reg;
        ly_n  = ystep ? ly_reg + PW'(1) : ly_reg;
        uy_n  = ystep ? uy_reg - PW'(1) : uy_reg;
        ly_t  = ly_reg + PW'(1);
        uy_t  = uy_reg - PW'(1);
        b_s   = (PW+1)'(b_reg);
        gap_m = ly_n - uy_n;
        gap_t = ly_t - uy_t;
        n_inc = n_reg + CNT_W'(1);
        under_cap   = (n_inc < CNT_W'(RESULT_CAP));
        cont_main   = (lx_n <= rx_n) && under_cap;
        cont_tail_m = (gap_m < b_s) && under_cap;
        cont_t      = (gap_t < b_s) && under_cap;
    end

    // ---------------- result assembly ----------------
    logic signed [PW-1:0] px [4];
    logic signed [PW-1:0] py [4];
    logic [3:0]           mask_next;
    logic                 last_next;
    logic signed [PW-1:0] lxm1, rxp1;

    always_comb
    begin
        lxm1 = lx_reg - PW'(1);
        rxp1 = rx_reg + PW'(1);
        py[0] = ly_reg;
        py[1] = ly_reg;
        py[2] = uy_reg;
        py[3] = uy_reg;
        if (state_reg == S_TAIL)
        begin
            px[0] = lxm1;
            px[1] = rxp1;
            px[2] = lxm1;
            px[3] = rxp1;
        end
        else
        begin
            px[0] = rx_reg;
            px[1] = lx_reg;
            px[2] = lx_reg;
            px[3] = rx_reg;
        end
        for (int i = 0; i < 4; i++)
        begin
            mask_next[i] = !px[i][PW-1] && !py[i][PW-1]
                && (ZW'(px[i][PW-2:0]) < ZW'(screen_width_reg))
                && (ZW'(py[i][PW-2:0]) < ZW'(screen_height_reg));
        end
        if (state_reg == S_OVER)
        begin
            for (int i = 0; i < 4; i++)
            begin
                px[i] = '0;
                py[i] = '0;
            end
            mask_next = '0;
        end
        unique case (state_reg)
            S_MAIN:  last_next = !cont_main && !cont_tail_m;
            S_TAIL:  last_next = !cont_t;
            S_OVER:  last_next = 1'b1;
            default: last_next = 1'b0;
        endcase
    end

    assign load = slot_free
        && (state_reg == S_MAIN || state_reg == S_TAIL || state_reg == S_OVER);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_SQA;
            S_SQA:   state_next = over_reg ? S_OVER : S_SQB;
            S_SQB:   state_next = S_DX;
            S_DX:    state_next = S_SETUP;
            S_SETUP: state_next = S_MAIN;
            S_MAIN:
            begin
                if (slot_free)
                begin
                    priority if (cont_main)   state_next = S_MAIN;
                    else if (cont_tail_m)     state_next = S_TAIL;
                    else                      state_next = S_IDLE;
                end
            end
            S_TAIL:  if (slot_free) state_next = cont_t ? S_TAIL : S_IDLE;
            S_OVER:  if (slot_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_SETUP)
                n_reg <= '0;
            else if (load && state_reg != S_OVER)
                n_reg <= n_inc;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_reg    <= a_full[SPAN_W-1:0];
                    b_reg    <= b_full[SPAN_W-1:0];
                    over_reg <= oversize;
                    minx_reg <= minx;
                    miny_reg <= miny;
                end
            end
            S_SQA: aa_reg  <= prod[SQ_W-1:0];
            S_SQB: bb_reg  <= prod[SQ_W-1:0];
            S_DX:  dxm_reg <= prod;
            S_SETUP:
            begin
                dx_reg   <= dx_init;
                dy_reg   <= dy_init;
                err_reg  <= err_init;
                xinc_reg <= bb_t <<< 3;
                yinc_reg <= aa_t <<< 3;
                lx_reg   <= PW'(minx_reg);
                rx_reg   <= PW'(minx_reg) + a_p;
                ly_reg   <= ly_init;
                uy_reg   <= ly_init - PW'(c_bit);
            end
            S_MAIN:
            begin
                if (slot_free)
                begin
                    dx_reg  <= dx_n;
                    dy_reg  <= dy_n;
                    err_reg <= err_n;
                    lx_reg  <= lx_n;
                    rx_reg  <= rx_n;
                    ly_reg  <= ly_n;
                    uy_reg  <= uy_n;
                end
            end
            S_TAIL:
            begin
                if (slot_free)
                begin
                    ly_reg <= ly_t;
                    uy_reg <= uy_t;
                end
            end
            default:
            begin
                over_reg <= over_reg;
            end
        endcase

        if (load)
        begin
            for (int i = 0; i < 4; i++)
            begin
                px_reg[i] <= px[i];
                py_reg[i] <= py[i];
            end
            mask_reg <= mask_next;
            last_reg <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign p0_x          = px_reg[0];
    assign p0_y          = py_reg[0];
    assign p1_x          = px_reg[1];
    assign p1_y          = py_reg[1];
    assign p2_x          = px_reg[2];
    assign p2_y          = py_reg[2];
    assign p3_x          = px_reg[3];
    assign p3_y          = py_reg[3];
    assign inside_mask   = mask_reg;
    assign last_of_shape = last_reg;

    // ---------------- assertions ----------------
    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(RESULT_CAP))
        else $error("result count passed the cap");

    assert property (@(posedge clk) disable iff (!rst_n)
        (load && last_next) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after last result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAIN) |-> (lx_reg <= rx_reg))
        else $error("main pass with left edge past right edge");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OVER) |-> over_reg)
        else $error("oversize pass for a rectangle within span");

endmodule

`default_nettype wire

FILE: verif/tb_ellipse_in_rect_rasterizer_top.sv
// Self-checking testbench for ellipse_in_rect_rasterizer_top: ellipse walk, tail passes,
// screen masking and oversized rectangles, checked against an in-bench predictor.
// Depends on eir_pkg and ellipse_in_rect_rasterizer_top.
`timescale 1ns / 1ps

module tb_ellipse_in_rect_rasterizer_top;

    import eir_pkg::*;

    localparam int SPAN_LIMIT  = 60;
    localparam int LIMIT_CYCLES = 1_000_000;

    typedef struct packed {
        logic signed [11:0] ax;
        logic signed [11:0] ay;
        logic signed [11:0] bx;
        logic signed [11:0] by;
    } rect_t;

    typedef struct packed {
        logic [3:0][12:0] px;
        logic [3:0][12:0] py;
        logic [3:0]       mask;
        logic             last;
    } quad_t;

    // Walk registers as they stand after the last rectangle
    typedef struct {
        int     left, right, upper, lower;
        longint err, dx, dy, xinc, yinc;
        int     span;
        bit     tail;
    } walk_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [11:0] corner_ax = '0;
    logic [11:0] corner_ay = '0;
    logic [11:0] corner_bx = '0;
    logic [11:0] corner_by = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [12:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
    logic [3:0]  inside_mask;
    logic        last_of_shape;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    rect_t       rect_q[$];
    quad_t       quad_q[$];
    rect_t       offered;
    walk_state_t walk = '{default: 0};

    int scr_w = 640;
    int scr_h = 480;

    int send_idle_pct = 0;
    int stall_pct = 0;
    bit rx_hold = 1'b0;

    int errors = 0;
    int n_shapes = 0;
    int n_oversized = 0;
    int n_tail = 0;
    int n_quads = 0;
    int cycles = 0;

    ellipse_in_rect_rasterizer_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .corner_ax(corner_ax), .corner_ay(corner_ay),
        .corner_bx(corner_bx), .corner_by(corner_by),
        .out_valid(out_valid), .out_stall(out_stall),
        .p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y),
        .p2_x(p2_x), .p2_y(p2_y), .p3_x(p3_x), .p3_y(p3_y),
        .inside_mask(inside_mask), .last_of_shape(last_of_shape),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic bit on_screen(int x, int y);
        return x >= 0 && y >= 0 && x < scr_w && y < scr_h;
    endfunction

    function automatic quad_t make_quad(int x0, int y0, int x1, int y1,
                                        int x2, int y2, int x3, int y3);
        quad_t q;
        int    xs[4];
        int    ys[4];
        xs = '{x0, x1, x2, x3};
        ys = '{y0, y1, y2, y3};
        q = '0;
        for (int i = 0; i < 4; i++)
        begin
            q.px[i] = 13'(xs[i]);
            q.py[i] = 13'(ys[i]);
            q.mask[i] = on_screen(xs[i], ys[i]);
        end
        return q;
    endfunction

    // Midpoint walk of the ellipse inscribed in the rectangle, one quad per pass
    function automatic void predict_ellipse(rect_t r);
        int     ax, ay, bx, by, a, b, c, lx, rx, uy, ly, n;
        longint dx, dy, err, e2, xinc, yinc;
        quad_t  quads[$];
        quad_t  q;
        ax = $signed(r.ax);
        ay = $signed(r.ay);
        bx = $signed(r.bx);
        by = $signed(r.by);
        a = bx >= ax ? bx - ax : ax - bx;
        b = by >= ay ? by - ay : ay - by;
        n_shapes++;
        walk.tail = 1'b0;
        if (a > SPAN_LIMIT || b > SPAN_LIMIT)
        begin
            q = '0;
            q.last = 1'b1;
            quad_q.push_back(q);
            n_oversized++;
            return;
        end
        c = b & 1;
        dx = 4 * (1 - a) * b * b;
        dy = 4 * (1 + c) * a * a;
        err = dx + dy + c * a * a;
        lx = ax < bx ? ax : bx;
        rx = lx + a;
        ly = (ay < by ? ay : by) + (b + 1) / 2;
        uy = ly - c;
        xinc = 8 * b * b;
        yinc = 8 * a * a;
        n = 0;
        do
        begin
            quads.push_back(make_quad(rx, ly, lx, ly, lx, uy, rx, uy));
            n++;
            e2 = 2 * err;
            if (e2 >= dx)
            begin
                lx++;
                rx--;
                dx += xinc;
                err += dx;
            end
            if (e2 <= dy)
            begin
                ly++;
                uy--;
                dy += yinc;
                err += dy;
            end
        end while (lx <= rx && n < RESULT_CAP);
        // flat ellipses: finish the tips
        while (ly - uy < b && n < RESULT_CAP)
        begin
            if (!walk.tail)
                n_tail++;
            walk.tail = 1'b1;
            quads.push_back(make_quad(lx - 1, ly, rx + 1, ly, lx - 1, uy, rx + 1, uy));
            n++;
            ly++;
            uy--;
        end
        q = quads.pop_back();
        q.last = 1'b1;
        quads.push_back(q);
        foreach (quads[i])
            quad_q.push_back(quads[i]);
        walk.left = lx;
        walk.right = rx;
        walk.upper = uy;
        walk.lower = ly;
        walk.err = err;
        walk.dx = dx;
        walk.dy = dy;
        walk.xinc = xinc;
        walk.yinc = yinc;
        walk.span = b;
    endfunction

    // Sender: offers queued rectangles, predicts on each accepted transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_ellipse(offered);
            if (!in_valid || !in_stall)
            begin
                if (rect_q.size() != 0 && int'($urandom_range(99, 0)) >= send_idle_pct)
                begin
                    offered = rect_q.pop_front();
                    in_valid <= 1'b1;
                    corner_ax <= offered.ax;
                    corner_ay <= offered.ay;
                    corner_bx <= offered.bx;
                    corner_by <= offered.by;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= rx_hold || int'($urandom_range(99, 0)) < stall_pct;
    end

    always @(posedge clk)
    begin : result_check
        quad_t got;
        quad_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.px = {p3_x, p2_x, p1_x, p0_x};
            got.py = {p3_y, p2_y, p1_y, p0_y};
            got.mask = inside_mask;
            got.last = last_of_shape;
            n_quads++;
            if (quad_q.size() == 0)
            begin
                $error("unexpected result transaction: p0=(%0d,%0d) mask %b last %b",
                       $signed(p0_x), $signed(p0_y), inside_mask, last_of_shape);
                errors++;
            end
            else
            begin
                want = quad_q.pop_front();
                for (int i = 0; i < 4; i++)
                begin
                    if (got.px[i] !== want.px[i])
                    begin
                        $error("p%0d_x: expected %0d, got %0d", i,
                               $signed(want.px[i]), $signed(got.px[i]));
                        errors++;
                    end
                    if (got.py[i] !== want.py[i])
                    begin
                        $error("p%0d_y: expected %0d, got %0d", i,
                               $signed(want.py[i]), $signed(got.py[i]));
                        errors++;
                    end
                end
                if (got.mask !== want.mask)
                begin
                    $error("inside_mask: expected %b, got %b", want.mask, got.mask);
                    errors++;
                end
                if (got.last !== want.last)
                begin
                    $error("last_of_shape: expected %b, got %b", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, quad_q.size());
            $display("[ellipse_in_rect_rasterizer_top] ERROR");
            $finish;
        end
    end

    task automatic add_rect(int ax, int ay, int bx, int by);
        rect_t r;
        r.ax = 12'(ax);
        r.ay = 12'(ay);
        r.bx = 12'(bx);
        r.by = 12'(by);
        rect_q.push_back(r);
    endtask

    // Mostly small rectangles near the screen, some anywhere, a few raw-noise corners
    task automatic add_random_rect();
        int pick, a, b, x0, y0;
        pick = $urandom_range(99, 0);
        if (pick >= 90)
        begin
            add_rect($urandom, $urandom, $urandom, $urandom);
            return;
        end
        a = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 40) : $urandom_range(24, 0);
        b = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 40) : $urandom_range(24, 0);
        if ($urandom_range(19, 0) == 0)
            a = 61;
        if (pick < 55)
        begin
            x0 = int'($urandom_range(scr_w + 100, 0)) - 80;
            y0 = int'($urandom_range(scr_h + 100, 0)) - 80;
        end
        else
        begin
            x0 = int'($urandom_range(4095, 0)) - 2048;
            y0 = int'($urandom_range(4095, 0)) - 2048;
        end
        if (x0 + a > 2047)
            x0 = 2047 - a;
        if (y0 + b > 2047)
            y0 = 2047 - b;
        if ($urandom_range(1, 0))
        begin
            if ($urandom_range(1, 0))
                add_rect(x0 + a, y0, x0, y0 + b);
            else
                add_rect(x0 + a, y0 + b, x0, y0);
        end
        else
        begin
            if ($urandom_range(1, 0))
                add_rect(x0, y0 + b, x0 + a, y0);
            else
                add_rect(x0, y0, x0 + a, y0 + b);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (rect_q.size() != 0 || in_valid || quad_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic idx, int val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_SCREEN_WIDTH)
            scr_w = val & 12'hFFF;
        else
            scr_h = val & 12'hFFF;
    endtask

    // Only called with the block drained; waits for the sequencer to settle, then writes both sizes
    task automatic set_screen(int w, int h);
        repeat (8) @(posedge clk);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
    endtask

    task automatic run_random(int count, int idle_pct, int stall_pct_i);
        @(negedge clk);
        send_idle_pct = idle_pct;
        stall_pct = stall_pct_i;
        repeat (count) add_random_rect();
        wait_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed shapes at the reset screen size
        add_rect(100, 100, 100, 100);
        add_rect(10, 20, 10, 30);
        add_rect(50, 40, 62, 40);
        add_rect(0, 0, 60, 60);
        add_rect(300, 200, 240, 140);
        add_rect(0, 0, 61, 10);
        add_rect(0, 0, 10, 61);
        add_rect(-2048, -2048, 2047, 2047);
        add_rect(-2048, -2048, -1988, -1988);
        add_rect(2047, 2047, 1987, 1987);
        add_rect(100, 100, 160, 101);
        add_rect(100, 200, 160, 202);
        add_rect(100, 300, 157, 303);
        add_rect(400, 100, 401, 160);
        add_rect(620, 460, 650, 490);
        add_rect(-10, -8, 12, 9);
        add_rect(500, 50, 480, 70);
        add_rect(200, 400, 230, 370);
        add_rect(-2048, 2047, -2048, 2047);
        add_rect(2047, -2048, 1990, -2000);
        add_rect(639, 479, 639, 479);
        add_rect(640, 480, 640, 480);
        wait_drained();
        run_random(40, 0, 0);

        set_screen(4095, 4095);
        run_random(90, 82, 0);

        set_screen(1, 1);
        run_random(70, 0, 82);

        set_screen(0, 300);
        run_random(50, 19, 19);

        set_screen(4095, 0);
        run_random(40, 0, 0);

        // receiver backs off for a long stretch while rectangles keep coming
        set_screen(320, 240);
        @(negedge clk);
        send_idle_pct = 0;
        stall_pct = 19;
        rx_hold = 1'b1;
        fork
            begin
                repeat (800) @(negedge clk);
                rx_hold = 1'b0;
            end
        join_none
        repeat (60) add_random_rect();
        wait_drained();

        set_screen(640, 480);
        run_random(60, 19, 19);

        repeat (16) @(posedge clk);
        $display("ran %0d rectangles (%0d oversized, %0d with tail passes), %0d quads checked",
                 n_shapes, n_oversized, n_tail, n_quads);
        $display("screen sizes from 0 to 4095 per axis, with sender gaps and receiver stalls");
        if (errors == 0 && quad_q.size() == 0)
            $display("[ellipse_in_rect_rasterizer_top] OK");
        else
            $display("[ellipse_in_rect_rasterizer_top] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
sv/eir_pkg.sv
sv/ellipse_in_rect_rasterizer_top.sv
verif/tb_ellipse_in_rect_rasterizer_top.sv
